// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BB3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bb3 assertion failed");
`define BB3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bb3 assertion failed");
`else
`define BB3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BB3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/bb3_pkg.sv -----
// Types and constants of the 3x3 RGB box blur.
package bb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic produce;
        logic last;
        logic top;
        logic bot;
        logic left;
        logic right;
    } ctrl_t;

    typedef struct packed {
        rgb_t  pix;
        ctrl_t ctrl;
    } work_t;

endpackage

// ----- design/bb3_front.sv -----
// Front end: accepts items, tracks frame position, classifies each item.
module bb3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [10:0]        cfg_width,
    input  logic [12:0]        cfg_height,
    input  logic               cfg_wr,
    input  logic               s_valid,
    output logic               s_ready,
    input  bb3_pkg::in_item_t  s_data,
    input  logic               full,
    output logic               push,
    output logic [CW-1:0]      push_col,
    output bb3_pkg::work_t     push_work
);
    import bb3_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic          in_frame, drop, accept;
    ctrl_t         ctrl;

    always_comb begin
        if (cfg_width == 11'd0) begin
            w_eff = WW'(1);
        end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_width);
        end
        if (cfg_height == 13'd0) begin
            h_eff = HW'(1);
        end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(cfg_height);
        end
    end

    assign s_ready  = !full;
    assign accept   = s_valid && s_ready;
    assign in_frame = 32'(in_row_reg) < 32'(h_eff);
    assign drop     = (s_data.req_type == REQ_FLUSH) && in_frame;
    assign push     = accept && !drop;
    assign push_col = in_col_reg;

    always_comb begin
        ctrl.produce = (32'(in_row_reg) >= 32'd2) ||
                       ((32'(in_row_reg) == 32'd1) && (in_col_reg != '0));
        ctrl.top   = out_row_reg != '0;
        ctrl.bot   = 32'(out_row_reg) + 32'd1 < 32'(h_eff);
        ctrl.left  = out_col_reg != '0;
        ctrl.right = 32'(out_col_reg) + 32'd1 < 32'(w_eff);
        ctrl.last  = ctrl.produce && (32'(out_row_reg) + 32'd1 == 32'(h_eff)) &&
                     (32'(out_col_reg) + 32'd1 == 32'(w_eff));
        push_work.ctrl = ctrl;
        if (in_frame) begin
            push_work.pix = '{r: s_data.red_in, g: s_data.green_in, b: s_data.blue_in};
        end else begin
            push_work.pix = '0;
        end
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (push) begin
            if (32'(in_col_reg) + 32'd1 >= 32'(w_eff)) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (ctrl.produce) begin
                if (32'(out_col_reg) + 32'd1 >= 32'(w_eff)) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end else begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
            if (ctrl.last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

// ----- design/bb3_queue.sv -----
// Short FIFO between front end and back end.
module bb3_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] din,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          empty
);
    import bb3_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] cnt_reg;

    assign full  = cnt_reg == NW'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + NW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - NW'(1);
            end
        end
    end

endmodule

// ----- design/bb3_back.sv -----
// Back end: line buffers, 3x3 window, masked sums and reciprocal rounding divide.
module bb3_back #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               empty,
    output logic               pop,
    input  logic [CW-1:0]      q_col,
    input  bb3_pkg::work_t     q_work,
    output logic               m_valid,
    input  logic               m_ready,
    output bb3_pkg::out_item_t m_data
);
    import bb3_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    work_t         cur_reg;
    logic [CW-1:0] col_reg;
    rgb_t          rd0_reg, rd1_reg;
    rgb_t          win_reg [3][3];
    rgb_t          lb0 [MAX_WIDTH];
    rgb_t          lb1 [MAX_WIDTH];
    logic [12:0]   num_reg [3];
    logic [17:0]   rcp_reg;
    out_item_t     out_reg;

    logic [2:0]    rowm, colm;
    logic [11:0]   sum [3];
    logic [3:0]    cnt;
    logic [12:0]   num [3];
    logic [17:0]   rcp;
    logic [30:0]   prod [3];

    assign pop     = (state_reg == ST_IDLE) && !empty;
    assign m_valid = state_reg == ST_OUT;
    assign m_data  = out_reg;

    always_comb begin
        rowm = {cur_reg.ctrl.bot, 1'b1, cur_reg.ctrl.top};
        colm = {cur_reg.ctrl.right, 1'b1, cur_reg.ctrl.left};
        for (int c = 0; c < 3; c++) begin
            sum[c] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
                if (rowm[k] && colm[l]) begin
                    sum[0] = sum[0] + 12'(win_reg[k][l].r);
                    sum[1] = sum[1] + 12'(win_reg[k][l].g);
                    sum[2] = sum[2] + 12'(win_reg[k][l].b);
                end
            end
        end
        cnt = (4'd1 + 4'(cur_reg.ctrl.top) + 4'(cur_reg.ctrl.bot)) *
              (4'd1 + 4'(cur_reg.ctrl.left) + 4'(cur_reg.ctrl.right));
        for (int c = 0; c < 3; c++) begin
            num[c] = {sum[c], 1'b0} + 13'(cnt);
        end
        // ceil(2^18 / (2*cnt)), exact for every numerator up to 2*9*255+9
        case (cnt)
            4'd1:    rcp = 18'd131072;
            4'd2:    rcp = 18'd65536;
            4'd3:    rcp = 18'd43691;
            4'd4:    rcp = 18'd32768;
            4'd6:    rcp = 18'd21846;
            4'd9:    rcp = 18'd14564;
            default: rcp = '0;
        endcase
        for (int c = 0; c < 3; c++) begin
            prod[c] = 31'(num_reg[c]) * 31'(rcp_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!empty) state_next = ST_RD;
            ST_RD:   state_next = cur_reg.ctrl.produce ? ST_SUM : ST_IDLE;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && !empty) begin
            rd0_reg <= lb0[q_col];
            rd1_reg <= lb1[q_col];
        end
        if (state_reg == ST_RD) begin
            lb0[col_reg] <= rd1_reg;
            lb1[col_reg] <= cur_reg.pix;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cur_reg <= q_work;
                col_reg <= q_col;
            end
            ST_RD: begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= rd0_reg;
                win_reg[1][2] <= rd1_reg;
                win_reg[2][2] <= cur_reg.pix;
            end
            ST_SUM: begin
                for (int c = 0; c < 3; c++) begin
                    num_reg[c] <= num[c];
                end
                rcp_reg <= rcp;
            end
            ST_DIV: begin
                out_reg <= '{red_out: prod[0][25:18], green_out: prod[1][25:18],
                             blue_out: prod[2][25:18], last_pixel: cur_reg.ctrl.last};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/box_blur_3x3_rgb.sv -----
// 3x3 RGB box blur, top level with configuration port.
// Streams RGB pixels of a frame in raster order and returns, per pixel, the
// rounded-half-up mean of each channel over the in-frame part of its 3x3
// neighborhood. Results lag one row and one pixel behind the input; after
// the frame send flush items until the item flagged last_pixel comes out.
// The front end takes one item per cycle while its two-entry queue has
// room; flush items inside the frame are dropped there. The back end does
// a line buffer read and a window update for an item that yields no
// result, and adds sum, reciprocal multiply and output, waiting for
// m_ready, for one that does. It takes no new item until it is through
// with the current one, so its sequential steps set the throughput.
// Writing either register restarts the frame.
`include "assert_macros.svh"
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  bb3_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bb3_pkg::out_item_t m_data
);
    import bb3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = CW + $bits(work_t);

    logic [10:0]   width_reg;
    logic [12:0]   height_reg;
    logic          cfg_wr;
    logic          q_push, q_pop, q_full, q_empty;
    logic [CW-1:0] push_col, q_col;
    work_t         push_work, q_work;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[2]))
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .cfg_wr     (cfg_wr),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .full       (q_full),
        .push       (q_push),
        .push_col   (push_col),
        .push_work  (push_work)
    );

    bb3_queue #(
        .DW (DW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     ({push_col, push_work}),
        .full    (q_full),
        .pop     (q_pop),
        .dout    ({q_col, q_work}),
        .empty   (q_empty)
    );

    bb3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (q_empty),
        .pop     (q_pop),
        .q_col   (q_col),
        .q_work  (q_work),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `BB3_ASSERT_IMP(a_no_overflow, aclk, aresetn, q_push, !q_full)
    `BB3_ASSERT_IMP(a_no_underflow, aclk, aresetn, q_pop, !q_empty)
    `BB3_ASSERT_NXT(a_pop_not_while_out, aclk, aresetn, m_valid && !m_ready, !q_pop)

endmodule
